/* sv/msbq_pkg.sv */
// Shared constants and types of the multi-section biquad filter bank.
`default_nettype none

package msbq_pkg;

    localparam int MAX_SECTIONS = 8;
    localparam int SAMPLE_BITS  = 24;
    localparam int COEF_BITS    = 32;
    localparam int NUM_COEFS    = 5;

    localparam int COEF_FRAC = COEF_BITS - 4;
    localparam int SEC_W     = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W     = 4;
    localparam int SEL_W     = 3;
    localparam int OP_W      = 2;
    localparam int PROD_W    = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_W     = PROD_W + 3;
    localparam int SHR_W     = ACC_W - COEF_FRAC;

    localparam int IN_DATA_RAW_W = SEC_W + SEL_W + COEF_BITS + SAMPLE_BITS;
    localparam int IN_DATA_W     = ((IN_DATA_RAW_W + 7) / 8) * 8;
    localparam int OUT_DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_COEF   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    localparam logic [SEL_W-1:0] COEF_A0 = 3'd0;
    localparam logic [SEL_W-1:0] COEF_A1 = 3'd1;
    localparam logic [SEL_W-1:0] COEF_A2 = 3'd2;
    localparam logic [SEL_W-1:0] COEF_B1 = 3'd3;
    localparam logic [SEL_W-1:0] COEF_B2 = 3'd4;

endpackage

`default_nettype wire

/* sv/multi_section_biquad_filter.sv */
// Top level of the multi-section direct-form-I biquad filter bank.
`default_nettype none

// The block takes one item per clock cycle unless a result waits in a stalled output
// register. The item is held in an input register; when it moves on, the five
// coefficient products, their sum, rounding and saturation are formed and loaded
// into the output register while the section history is updated. That loop through
// the five multipliers and the adder is what sets the clock. Coefficients (5 x 8
// words) and history live in flip-flops and are cleared by reset, so no clearing
// pass is needed. A sample item always gives one result; a coefficient item gives
// one only for a bad section with a valid coefficient select.
module multi_section_biquad_filter (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_cfg_we,
    input  wire [msbq_pkg::CNT_W-1:0]               i_cfg_wdata,  // section_count
    input  wire                                     i_s_tvalid,
    output logic                                    o_s_tready,
    // section, coef_select, coef_value, sample_in, zero pad
    input  wire [msbq_pkg::IN_DATA_W-1:0]           i_s_tdata,
    input  wire [msbq_pkg::OP_W-1:0]                i_s_tuser,    // op
    output logic                                    o_m_tvalid,
    input  wire                                     i_m_tready,
    output logic [msbq_pkg::OUT_DATA_W-1:0]         o_m_tdata,    // sample_out
    output logic                                    o_m_tuser     // section_error
);

    localparam int SB = msbq_pkg::SAMPLE_BITS;
    localparam int CB = msbq_pkg::COEF_BITS;
    localparam int SW = msbq_pkg::SEC_W;
    localparam int LW = msbq_pkg::SEL_W;

    logic [msbq_pkg::CNT_W-1:0] r_section_count;

    logic                        r_in_valid;
    logic [msbq_pkg::OP_W-1:0]   r_op;
    logic [SW-1:0]               r_sec;
    logic [LW-1:0]               r_sel;
    logic signed [CB-1:0]        r_cval;
    logic signed [SB-1:0]        r_x;

    logic signed [CB-1:0] r_coef [msbq_pkg::NUM_COEFS][msbq_pkg::MAX_SECTIONS];
    logic signed [SB-1:0] r_x1   [msbq_pkg::MAX_SECTIONS];
    logic signed [SB-1:0] r_x2   [msbq_pkg::MAX_SECTIONS];
    logic signed [SB-1:0] r_y1   [msbq_pkg::MAX_SECTIONS];
    logic signed [SB-1:0] r_y2   [msbq_pkg::MAX_SECTIONS];

    logic                 r_out_valid;
    logic signed [SB-1:0] r_out_data;
    logic                 r_out_err;

    logic [msbq_pkg::CNT_W-1:0] w_active;
    logic                       w_sec_ok;
    logic                       w_sel_ok;
    logic                       w_has_result;
    logic                       w_adv;
    logic                       w_fire;
    logic                       w_do_sample;
    logic                       w_do_coef;
    logic                       w_do_clear;

    logic signed [msbq_pkg::PROD_W-1:0] w_p0, w_p1, w_p2, w_p3, w_p4;
    logic signed [msbq_pkg::ACC_W-1:0]  w_acc;
    logic signed [msbq_pkg::SHR_W-1:0]  w_shr;
    logic signed [SB-1:0]               w_y;

    localparam logic signed [msbq_pkg::SHR_W-1:0] LIM_HI =
        msbq_pkg::SHR_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [msbq_pkg::SHR_W-1:0] LIM_LO =
        msbq_pkg::SHR_W'(-(64'sd1 <<< (SB - 1)));
    localparam logic signed [msbq_pkg::ACC_W-1:0] HALF_LSB =
        msbq_pkg::ACC_W'(64'sd1 <<< (msbq_pkg::COEF_FRAC - 1));

    always_comb begin
        if (r_section_count > msbq_pkg::CNT_W'(msbq_pkg::MAX_SECTIONS)) begin
            w_active = msbq_pkg::CNT_W'(msbq_pkg::MAX_SECTIONS);
        end else begin
            w_active = r_section_count;
        end
    end

    assign w_sec_ok = (msbq_pkg::CNT_W'(r_sec) < w_active);
    assign w_sel_ok = (r_sel < LW'(msbq_pkg::NUM_COEFS));

    always_comb begin
        w_has_result = 1'b0;
        w_do_sample  = 1'b0;
        w_do_coef    = 1'b0;
        w_do_clear   = 1'b0;
        if (r_op == msbq_pkg::OP_SAMPLE) begin
            w_has_result = 1'b1;
            w_do_sample  = w_sec_ok;
        end else if (r_op == msbq_pkg::OP_COEF) begin
            w_has_result = w_sel_ok && !w_sec_ok;
            w_do_coef    = w_sel_ok && w_sec_ok;
        end else if (r_op == msbq_pkg::OP_CLEAR) begin
            w_do_clear   = 1'b1;
        end
    end

    assign w_adv      = !r_out_valid || i_m_tready;
    assign w_fire     = r_in_valid && (w_adv || !w_has_result);
    assign o_s_tready = !r_in_valid || w_fire;

    assign w_p0 = msbq_pkg::PROD_W'(r_coef[msbq_pkg::COEF_A0][r_sec] * r_x);
    assign w_p1 = msbq_pkg::PROD_W'(r_coef[msbq_pkg::COEF_A1][r_sec] * r_x1[r_sec]);
    assign w_p2 = msbq_pkg::PROD_W'(r_coef[msbq_pkg::COEF_A2][r_sec] * r_x2[r_sec]);
    assign w_p3 = msbq_pkg::PROD_W'(r_coef[msbq_pkg::COEF_B1][r_sec] * r_y1[r_sec]);
    assign w_p4 = msbq_pkg::PROD_W'(r_coef[msbq_pkg::COEF_B2][r_sec] * r_y2[r_sec]);

    always_comb begin
        w_acc = msbq_pkg::ACC_W'(w_p0) + msbq_pkg::ACC_W'(w_p1) + msbq_pkg::ACC_W'(w_p3)
              + msbq_pkg::ACC_W'(w_p2) + msbq_pkg::ACC_W'(w_p4) + HALF_LSB;
        w_shr = msbq_pkg::SHR_W'(w_acc >>> msbq_pkg::COEF_FRAC);
        if (w_shr > LIM_HI) begin
            w_y = SB'(LIM_HI);
        end else if (w_shr < LIM_LO) begin
            w_y = SB'(LIM_LO);
        end else begin
            w_y = SB'(w_shr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section_count <= msbq_pkg::CNT_W'(1);
        end else if (i_cfg_we) begin
            r_section_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_op   <= i_s_tuser;
            r_sec  <= i_s_tdata[SW-1:0];
            r_sel  <= i_s_tdata[SW +: LW];
            r_cval <= i_s_tdata[SW+LW +: CB];
            r_x    <= i_s_tdata[SW+LW+CB +: SB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < msbq_pkg::NUM_COEFS; c++) begin
                for (int s = 0; s < msbq_pkg::MAX_SECTIONS; s++) begin
                    r_coef[c][s] <= '0;
                end
            end
        end else if (w_fire && w_do_coef) begin
            r_coef[r_sel][r_sec] <= r_cval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < msbq_pkg::MAX_SECTIONS; s++) begin
                r_x1[s] <= '0;
                r_x2[s] <= '0;
                r_y1[s] <= '0;
                r_y2[s] <= '0;
            end
        end else if (w_fire && w_do_clear) begin
            for (int s = 0; s < msbq_pkg::MAX_SECTIONS; s++) begin
                r_x1[s] <= '0;
                r_x2[s] <= '0;
                r_y1[s] <= '0;
                r_y2[s] <= '0;
            end
        end else if (w_fire && w_do_sample) begin
            r_x2[r_sec] <= r_x1[r_sec];
            r_y2[r_sec] <= r_y1[r_sec];
            r_x1[r_sec] <= r_x;
            r_y1[r_sec] <= w_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_has_result) begin
            r_out_data <= w_do_sample ? w_y : '0;
            r_out_err  <= !w_sec_ok;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = msbq_pkg::OUT_DATA_W'($unsigned(r_out_data));
    assign o_m_tuser  = r_out_err;

endmodule

`default_nettype wire

/* sv/msbq_checker.sv */
// Port-level checks of the biquad filter bank, bound to its top level.
`default_nettype none

module msbq_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_s_tvalid,
    input wire                               o_s_tready,
    input wire                               o_m_tvalid,
    input wire                               i_m_tready,
    input wire [msbq_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input wire                               o_m_tuser
);

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

    property p_err_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0;
    endproperty
    a_err_zero: assert property (p_err_zero) else $error("error result carries a sample");

    property p_rise_needs_item;
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 2);
    endproperty
    a_rise_needs_item: assert property (p_rise_needs_item)
        else $error("result appeared without an accepted item");

    property p_stall_only_on_full;
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready;
    endproperty
    a_stall_only_on_full: assert property (p_stall_only_on_full)
        else $error("input stalled while output can drain");

endmodule

bind multi_section_biquad_filter msbq_checker u_msbq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
